>>> rtl/lpfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpfs_pkg;

    localparam int CHANNELS   = 48;
    localparam int DUTY_W     = 16;
    localparam int IDX_W      = 10;
    localparam int GRAY_W     = CHANNELS * DUTY_W;

    typedef logic [1:0]        cmd_t;
    typedef logic [5:0]        chan_t;
    typedef logic [DUTY_W-1:0] duty_t;
    typedef logic [2:0]        cfg_idx_t;
    typedef logic [6:0]        cfg_data_t;
    typedef logic [IDX_W-1:0]  bit_idx_t;
    typedef logic [2:0]        phase_t;

    // command codes
    localparam cmd_t CMD_WRITE    = 2'd0;
    localparam cmd_t CMD_TICK     = 2'd1;
    localparam cmd_t CMD_SHUTDOWN = 2'd2;
    localparam cmd_t CMD_NOP      = 2'd3;

    // register indexes
    localparam cfg_idx_t REG_DOT_CORRECTION  = 3'd0;
    localparam cfg_idx_t REG_MAX_CURRENT     = 3'd1;
    localparam cfg_idx_t REG_BRIGHTNESS      = 3'd2;
    localparam cfg_idx_t REG_AUTO_REPEAT     = 3'd3;
    localparam cfg_idx_t REG_TIMING_RESET    = 3'd4;
    localparam cfg_idx_t REG_AUTO_REFRESH    = 3'd5;
    localparam cfg_idx_t REG_SPREAD_PWM      = 3'd6;
    localparam cfg_idx_t REG_LSD_VOLTAGE_SEL = 3'd7;

    // phase codes
    localparam phase_t PH_CTRL1 = 3'd0;
    localparam phase_t PH_CTRL2 = 3'd1;
    localparam phase_t PH_IDLE  = 3'd2;
    localparam phase_t PH_GRAY  = 3'd3;
    localparam phase_t PH_DONE  = 3'd4;

    // frame bit positions
    localparam bit_idx_t FRAME_BITS     = 10'd776;
    localparam bit_idx_t POS_MODE_BIT   = 10'd7;
    localparam bit_idx_t POS_ID_FIRST   = 10'd8;
    localparam bit_idx_t POS_ID_LAST    = 10'd15;
    localparam bit_idx_t POS_FC_FIRST   = 10'd400;
    localparam bit_idx_t POS_FC_LAST    = 10'd439;
    localparam bit_idx_t POS_DC_FIRST   = 10'd440;
    localparam bit_idx_t POS_GRAY_FIRST = 10'd8;

    localparam logic [7:0] CTRL_ID = 8'h96;
    localparam logic [2:0] DC_LAST = 3'd6;

endpackage

`default_nettype wire

>>> rtl/led_pwm_frame_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

// each input transfer's result is in the output register in the next cycle
// throughput: one item per cycle while out_ready is high; the output register frees a slot as it is taken
// grayscale data is snapshotted into a 768-bit shift line when a frame starts
// reset (rst_n low, async): duties zero, registers at defaults, phase first control
// frame; the first tick after reset starts shifting the control frame

module led_pwm_frame_serializer (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  lpfs_pkg::cmd_t     cmd,
    input  lpfs_pkg::chan_t    channel,
    input  lpfs_pkg::duty_t    duty,
    output logic               out_valid,
    input  wire                out_ready,
    output logic               serial_bit,
    output logic               bit_valid,
    output logic               latch_pulse,
    output logic               init_done,
    output logic               shutdown_done,
    input  wire                cfg_write,
    input  lpfs_pkg::cfg_idx_t cfg_index,
    input  lpfs_pkg::cfg_data_t cfg_data
);
    import lpfs_pkg::*;

    logic [6:0] dc_reg;
    logic [2:0] mc_reg;
    logic [6:0] bc_reg;
    logic       ar_reg, tr_reg, rf_reg, sp_reg, lsd_reg;

    duty_t        duty_reg [CHANNELS];
    logic [GRAY_W-1:0] gray_reg, gray_next;
    bit_idx_t     bit_index_reg, bit_index_next;
    phase_t       phase_reg, phase_next;
    logic         pending_reg, pending_next;
    logic         shutdown_req_reg, shutdown_req_next;
    logic [2:0]   rep_reg, rep_next;

    logic out_valid_reg;
    logic sbit_reg, valid_reg, latch_reg, init_reg, sdone_reg;

    logic       accept, is_tick, start_gray, shifting, gray_ph;
    logic       sbit, vbit, latch;
    logic       ctrl_bit;
    logic [39:0] fc_vec;
    bit_idx_t   fc_off;
    logic [GRAY_W-1:0] snap;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_tick  = accept && (cmd == CMD_TICK);

    // function-control bytes 50..54 as one bit string, first sent at the top
    assign fc_vec = {5'b0, lsd_reg, sp_reg, rf_reg, tr_reg, ar_reg,
                     bc_reg, bc_reg, bc_reg, mc_reg, mc_reg, mc_reg};
    assign fc_off = POS_FC_LAST - bit_index_reg;

    always_comb
    begin
        ctrl_bit = 1'b0;
        if (bit_index_reg == POS_MODE_BIT)
        begin
            ctrl_bit = 1'b1;
        end
        else if (bit_index_reg >= POS_ID_FIRST && bit_index_reg <= POS_ID_LAST)
        begin
            ctrl_bit = CTRL_ID[~bit_index_reg[2:0]];
        end
        else if (bit_index_reg >= POS_FC_FIRST && bit_index_reg <= POS_FC_LAST)
        begin
            ctrl_bit = fc_vec[fc_off[5:0]];
        end
        else if (bit_index_reg >= POS_DC_FIRST)
        begin
            ctrl_bit = dc_reg[DC_LAST - rep_reg];
        end
    end

    // snapshot of the duty store, channel 0 high byte first
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            snap[GRAY_W-1-c*DUTY_W -: DUTY_W] = duty_reg[c];
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        pending_next      = pending_reg;
        shutdown_req_next = shutdown_req_reg;
        rep_next          = rep_reg;
        gray_next         = gray_reg;
        sbit              = 1'b0;
        vbit              = 1'b0;
        latch             = 1'b0;
        start_gray        = 1'b0;
        shifting          = 1'b0;
        gray_ph           = 1'b0;

        if (accept && cmd == CMD_WRITE && channel < 6'(CHANNELS))
        begin
            pending_next = 1'b1;
        end
        if (accept && cmd == CMD_SHUTDOWN)
        begin
            pending_next      = 1'b1;
            shutdown_req_next = 1'b1;
        end

        if (is_tick)
        begin
            start_gray = (phase_reg == PH_IDLE) && pending_reg;
            gray_ph    = (phase_reg == PH_GRAY) || start_gray;
            shifting   = gray_ph || (phase_reg == PH_CTRL1) || (phase_reg == PH_CTRL2);
            if (start_gray)
            begin
                gray_next    = snap;
                pending_next = 1'b0;
            end
            if (shifting)
            begin
                if (bit_index_reg < FRAME_BITS)
                begin
                    vbit           = 1'b1;
                    bit_index_next = bit_index_reg + 10'd1;
                    if (gray_ph)
                    begin
                        if (bit_index_reg >= POS_GRAY_FIRST)
                        begin
                            sbit      = gray_reg[GRAY_W-1];
                            gray_next = {gray_reg[GRAY_W-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        sbit = ctrl_bit;
                        if (bit_index_reg >= POS_DC_FIRST)
                        begin
                            rep_next = (rep_reg == DC_LAST) ? 3'd0 : rep_reg + 3'd1;
                        end
                    end
                end
                else
                begin
                    latch          = 1'b1;
                    bit_index_next = '0;
                    rep_next       = '0;
                    if (phase_reg == PH_CTRL1)
                    begin
                        phase_next = PH_CTRL2;
                    end
                    else if (phase_reg == PH_CTRL2)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (shutdown_req_reg && !pending_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                if (start_gray && !latch)
                begin
                    phase_next = PH_GRAY;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg  <= 7'd127;
            mc_reg  <= 3'd0;
            bc_reg  <= 7'd127;
            ar_reg  <= 1'b1;
            tr_reg  <= 1'b0;
            rf_reg  <= 1'b0;
            sp_reg  <= 1'b1;
            lsd_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DOT_CORRECTION:  dc_reg  <= cfg_data;
                REG_MAX_CURRENT:     mc_reg  <= cfg_data[2:0];
                REG_BRIGHTNESS:      bc_reg  <= cfg_data;
                REG_AUTO_REPEAT:     ar_reg  <= cfg_data[0];
                REG_TIMING_RESET:    tr_reg  <= cfg_data[0];
                REG_AUTO_REFRESH:    rf_reg  <= cfg_data[0];
                REG_SPREAD_PWM:      sp_reg  <= cfg_data[0];
                REG_LSD_VOLTAGE_SEL: lsd_reg <= cfg_data[0];
                default:             dc_reg  <= dc_reg;
            endcase
        end
    end

    // duty store, cleared as a whole by shutdown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                duty_reg[c] <= '0;
            end
        end
        else if (accept && cmd == CMD_SHUTDOWN)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                duty_reg[c] <= '0;
            end
        end
        else if (accept && cmd == CMD_WRITE && channel < 6'(CHANNELS))
        begin
            duty_reg[channel] <= duty;
        end
    end

    // shift line starts from zero so an untouched frame reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg <= '0;
        end
        else
        begin
            gray_reg <= gray_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_CTRL1;
            bit_index_reg    <= '0;
            pending_reg      <= 1'b0;
            shutdown_req_reg <= 1'b0;
            rep_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            pending_reg      <= pending_next;
            shutdown_req_reg <= shutdown_req_next;
            rep_reg          <= rep_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sbit_reg  <= sbit;
            valid_reg <= vbit;
            latch_reg <= latch;
            init_reg  <= (phase_next == PH_IDLE) || (phase_next == PH_GRAY)
                         || (phase_next == PH_DONE);
            sdone_reg <= (phase_next == PH_DONE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign serial_bit    = sbit_reg;
    assign bit_valid     = valid_reg;
    assign latch_pulse   = latch_reg;
    assign init_done     = init_reg;
    assign shutdown_done = sdone_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= FRAME_BITS)
        else $error("bit index past the latch tick");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_DONE) |-> (bit_index_reg == '0))
        else $error("bit index not at frame start outside a frame");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("left the done phase");

    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg <= DC_LAST)
        else $error("dot correction bit counter out of range");

    a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sdone_reg) |-> (init_reg && !valid_reg))
        else $error("shutdown done without init done or with a frame bit");

    a_latch_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && latch) |=> (phase_reg != PH_GRAY && bit_index_reg == '0))
        else $error("latch did not close the frame");

endmodule

`default_nettype wire
